// ----- rtl/core/isgd_pkg.sv -----
// Shared types, constants and tables of the shake and tilt gesture detector.
package isgd_pkg;

    localparam int ACCUM_BITS_DEF   = 24;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_XY_W      = 27;
    localparam int CORDIC_Z_W       = 26;
    localparam int PITCH_W          = 15;

    localparam logic [6:0]  DT_CAP_MS   = 7'd100;
    localparam logic [13:0] PITCH_LIMIT = 14'd11520;
    localparam logic signed [CORDIC_Z_W-1:0] QUARTER_TURN = CORDIC_Z_W'(90 * 65536);

    localparam logic [14:0] GYRO_THR_RST    = 15'd1600;
    localparam logic [15:0] SHAKE_TRIG_RST  = 16'd300;
    localparam logic [15:0] SHAKE_COOL_RST  = 16'd2000;
    localparam logic [13:0] TILT_THR_RST    = 14'd1280;
    localparam logic [15:0] TILT_COOL_RST   = 16'd400;
    localparam logic [15:0] CALIB_DELAY_RST = 16'd1500;

    typedef enum logic [2:0] {
        CFG_GYRO_THR    = 3'd0,
        CFG_SHAKE_TRIG  = 3'd1,
        CFG_SHAKE_COOL  = 3'd2,
        CFG_TILT_THR    = 3'd3,
        CFG_TILT_COOL   = 3'd4,
        CFG_CALIB_DELAY = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_RUN,
        ST_UPD,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ITER,
        CS_ROUND
    } t_cs_state;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic               gyro_ok;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic               accel_ok;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } t_in_word;

    typedef struct packed {
        logic shake_fire;
        logic tilt_fire;
        logic tilt_positive;
        logic is_calibrated;
    } t_out_word;

    // atan(2^-i) in 1/65536 degree
    function automatic logic signed [CORDIC_Z_W-1:0] atan_entry(input logic [4:0] i);
        logic signed [CORDIC_Z_W-1:0] v;
        case (i)
            5'd0:    v = CORDIC_Z_W'(2949120);
            5'd1:    v = CORDIC_Z_W'(1740967);
            5'd2:    v = CORDIC_Z_W'(919879);
            5'd3:    v = CORDIC_Z_W'(466945);
            5'd4:    v = CORDIC_Z_W'(234379);
            5'd5:    v = CORDIC_Z_W'(117304);
            5'd6:    v = CORDIC_Z_W'(58666);
            5'd7:    v = CORDIC_Z_W'(29335);
            5'd8:    v = CORDIC_Z_W'(14668);
            5'd9:    v = CORDIC_Z_W'(7334);
            5'd10:   v = CORDIC_Z_W'(3667);
            5'd11:   v = CORDIC_Z_W'(1833);
            5'd12:   v = CORDIC_Z_W'(917);
            5'd13:   v = CORDIC_Z_W'(458);
            5'd14:   v = CORDIC_Z_W'(229);
            5'd15:   v = CORDIC_Z_W'(115);
            5'd16:   v = CORDIC_Z_W'(57);
            5'd17:   v = CORDIC_Z_W'(29);
            5'd18:   v = CORDIC_Z_W'(14);
            5'd19:   v = CORDIC_Z_W'(7);
            5'd20:   v = CORDIC_Z_W'(4);
            5'd21:   v = CORDIC_Z_W'(2);
            5'd22:   v = CORDIC_Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/imu_shake_tilt_gesture_detector.sv -----
// Top level of the IMU shake and tilt gesture detector.
//
// Takes one IMU sample word at a time and returns one result word per sample:
// shake_fire, tilt_fire, tilt_positive and is_calibrated. The processing time
// is set by the bit-serial squarer, which squares each of the three gyro axes
// and the shake threshold one multiplier bit at a time; the CORDIC pitch unit
// runs alongside it. The input stalls from acceptance until the result moves
// into the output register; a finished result may wait there while the next
// sample is accepted. Configuration registers are written through the cfg
// channel, which is always ready; write them only while the block is idle.
module imu_shake_tilt_gesture_detector
    import isgd_pkg::*;
#(
    parameter int ACCUM_BITS   = ACCUM_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample input
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_word    i_data,
    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_word   o_data,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // configuration
    logic [14:0] r_gyro_thr;
    logic [15:0] r_shake_trig, r_shake_cool, r_tilt_cool, r_calib_delay;
    logic [13:0] r_tilt_thr;

    // control and state
    t_state    r_state, n_state;
    t_in_word  r_in;
    logic      r_sq_flag, r_co_flag;
    logic [ACCUM_BITS-1:0] r_accum;
    logic [31:0] r_last_gyro, r_last_shake, r_calib_start, r_last_tilt;
    logic signed [PITCH_W-1:0] r_neutral, r_pitch_eff;
    logic      r_cal;
    logic      r_out_valid;
    t_out_word r_out;

    logic sq_done, co_done;
    logic [31:0] mag2, thr2;
    logic signed [PITCH_W-1:0] pitch;
    logic start;
    logic out_free;

    // shake arithmetic
    logic [31:0] dt_raw;
    logic [6:0]  dt_cap;
    logic [10:0] inc, dec;
    logic [ACCUM_BITS:0] acc_sum;
    logic [ACCUM_BITS-1:0] acc_up, acc_dn;
    logic [19:0] trig10;
    logic shake_now, tilt_now, tilt_pos, calib_now;
    logic signed [PITCH_W:0] delta;
    logic [PITCH_W:0] delta_mag;

    assign o_cfg_ready = 1'b1;

    // hold the configuration registers, mask each to its width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_thr    <= GYRO_THR_RST;
            r_shake_trig  <= SHAKE_TRIG_RST;
            r_shake_cool  <= SHAKE_COOL_RST;
            r_tilt_thr    <= TILT_THR_RST;
            r_tilt_cool   <= TILT_COOL_RST;
            r_calib_delay <= CALIB_DELAY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_GYRO_THR:    r_gyro_thr    <= i_cfg_data[14:0];
                CFG_SHAKE_TRIG:  r_shake_trig  <= i_cfg_data;
                CFG_SHAKE_COOL:  r_shake_cool  <= i_cfg_data;
                CFG_TILT_THR:    r_tilt_thr    <= i_cfg_data[13:0];
                CFG_TILT_COOL:   r_tilt_cool   <= i_cfg_data;
                CFG_CALIB_DELAY: r_calib_delay <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign start = (r_state == ST_START);

    isgd_sq u_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_gx    (r_in.gyro_x),
        .i_gy    (r_in.gyro_y),
        .i_gz    (r_in.gyro_z),
        .i_thr   (r_gyro_thr),
        .o_done  (sq_done),
        .o_mag2  (mag2),
        .o_thr2  (thr2)
    );

    isgd_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_ay    (r_in.accel_y),
        .i_az    (r_in.accel_z),
        .o_done  (co_done),
        .o_pitch (pitch)
    );

    // the output register is free when empty or being drained this cycle
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != ST_IDLE);
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    // leaky accumulator update: gain 10*dt above threshold, else lose 3*dt
    always_comb begin
        dt_raw  = r_in.now_ms - r_last_gyro;
        dt_cap  = (dt_raw > 32'(DT_CAP_MS)) ? DT_CAP_MS : dt_raw[6:0];
        inc     = (11'(dt_cap) << 3) + (11'(dt_cap) << 1);
        dec     = (11'(dt_cap) << 1) + 11'(dt_cap);
        acc_sum = (ACCUM_BITS+1)'(r_accum) + (ACCUM_BITS+1)'(inc);
        acc_up  = acc_sum[ACCUM_BITS] ? {ACCUM_BITS{1'b1}} : acc_sum[ACCUM_BITS-1:0];
        acc_dn  = (r_accum > ACCUM_BITS'(dec)) ? r_accum - ACCUM_BITS'(dec) : '0;
    end

    // fire decisions, made once the accumulator and pitch have settled
    always_comb begin
        trig10    = (20'(r_shake_trig) << 3) + (20'(r_shake_trig) << 1);
        shake_now = r_in.gyro_ok && (33'(r_accum) >= 33'(trig10))
                 && ((r_in.now_ms - r_last_shake) >= 32'(r_shake_cool));
        delta     = (PITCH_W+1)'(r_pitch_eff) - (PITCH_W+1)'(r_neutral);
        delta_mag = delta[PITCH_W] ? (PITCH_W+1)'(-delta) : (PITCH_W+1)'(delta);
        tilt_now  = r_cal && (delta_mag > (PITCH_W+1)'(r_tilt_thr))
                 && ((r_in.now_ms - r_last_tilt) >= 32'(r_tilt_cool));
        tilt_pos  = tilt_now && !delta[PITCH_W] && (delta != '0);
        calib_now = !r_cal && (r_calib_start != 32'd0)
                 && ((r_in.now_ms - r_calib_start) > 32'(r_calib_delay));
    end

    // sequencer: capture, run the serial units, update, finish
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_valid) n_state = ST_START;
            ST_START: n_state = ST_RUN;
            ST_RUN:   if (r_sq_flag && r_co_flag) n_state = ST_UPD;
            ST_UPD:   n_state = ST_FIN;
            ST_FIN:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_flag     <= 1'b0;
            r_co_flag     <= 1'b0;
            r_accum       <= '0;
            r_last_gyro   <= '0;
            r_last_shake  <= '0;
            r_calib_start <= '0;
            r_last_tilt   <= '0;
            r_neutral     <= '0;
            r_cal         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            // drop the drained word unless a new one loads this cycle
            if (r_out_valid && !i_stall && !((r_state == ST_FIN) && out_free)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_in <= i_data;
                    end
                end
                ST_START: begin
                    r_sq_flag <= 1'b0;
                    r_co_flag <= 1'b0;
                end
                ST_RUN: begin
                    if (sq_done) r_sq_flag <= 1'b1;
                    if (co_done) r_co_flag <= 1'b1;
                end
                ST_UPD: begin
                    r_pitch_eff <= r_in.accel_ok ? pitch : '0;
                    if (r_in.gyro_ok) begin
                        r_last_gyro <= r_in.now_ms;
                        r_accum     <= (mag2 > thr2) ? acc_up : acc_dn;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        if (shake_now) begin
                            r_accum      <= '0;
                            r_last_shake <= r_in.now_ms;
                        end
                        if (!r_cal) begin
                            if (r_calib_start == 32'd0) begin
                                r_calib_start <= r_in.now_ms;
                            end else if (calib_now) begin
                                r_neutral <= r_pitch_eff;
                                r_cal     <= 1'b1;
                            end
                        end
                        if (tilt_now) begin
                            r_last_tilt <= r_in.now_ms;
                        end
                        r_out.shake_fire    <= shake_now;
                        r_out.tilt_fire     <= tilt_now;
                        r_out.tilt_positive <= tilt_pos;
                        r_out.is_calibrated <= r_cal || calib_now;
                        r_out_valid         <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == ST_START))
        else $error("accepted word did not start the serial units");

    a_calib_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cal |=> r_cal)
        else $error("calibration latch dropped");

    a_dir_needs_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.tilt_fire || !o_data.tilt_positive))
        else $error("tilt direction set without a tilt event");

    a_units_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> (r_sq_flag && r_co_flag))
        else $error("update reached before serial units finished");

endmodule

// ----- rtl/core/isgd_sq.sv -----
// Bit-serial squarer: gyro magnitude squared and threshold squared.
module isgd_sq
    import isgd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_gx,
    input  logic signed [15:0] i_gy,
    input  logic signed [15:0] i_gz,
    input  logic [14:0]        i_thr,
    output logic               o_done,
    output logic [31:0]        o_mag2,
    output logic [31:0]        o_thr2
);

    logic        r_busy;
    logic        r_done;
    logic [1:0]  r_op;
    logic [3:0]  r_bit;
    logic [31:0] r_mcand;
    logic [15:0] r_mplier;
    logic [31:0] r_mag;
    logic [31:0] r_thr;
    logic [15:0] next_opnd;
    logic [31:0] partial;

    function automatic logic [15:0] abs16(input logic signed [15:0] g);
        return g[15] ? 16'(-g) : 16'(g);
    endfunction

    always_comb begin
        case (r_op)
            2'd0:    next_opnd = abs16(i_gy);
            2'd1:    next_opnd = abs16(i_gz);
            default: next_opnd = {1'b0, i_thr};
        endcase
        partial = r_mplier[0] ? r_mcand : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= '0;
            r_bit  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_op     <= '0;
                r_bit    <= '0;
                r_mcand  <= {16'd0, abs16(i_gx)};
                r_mplier <= abs16(i_gx);
                r_mag    <= '0;
                r_thr    <= '0;
            end else if (r_busy) begin
                // add one partial product, advance one multiplier bit
                if (r_op == 2'd3) begin
                    r_thr <= r_thr + partial;
                end else begin
                    r_mag <= r_mag + partial;
                end
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_bit    <= r_bit + 4'd1;
                if (r_bit == 4'd15) begin
                    if (r_op == 2'd3) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_op     <= r_op + 2'd1;
                        r_bit    <= '0;
                        r_mcand  <= {16'd0, next_opnd};
                        r_mplier <= next_opnd;
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_mag2 = r_mag;
    assign o_thr2 = r_thr;

endmodule

// ----- rtl/core/isgd_cordic.sv -----
// Iterative vectoring CORDIC giving pitch atan2(ay, az) in 1/64 degree.
module isgd_cordic
    import isgd_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [15:0]        i_ay,
    input  logic signed [15:0]        i_az,
    output logic                      o_done,
    output logic signed [PITCH_W-1:0] o_pitch
);

    localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int QW = CORDIC_Z_W - 10;

    t_cs_state r_cs;
    logic      r_done;
    logic      r_zero;
    logic [IW-1:0] r_i;
    logic signed [CORDIC_XY_W-1:0] r_x, r_y;
    logic signed [CORDIC_Z_W-1:0]  r_z;
    logic signed [PITCH_W-1:0]     r_pitch;

    logic signed [CORDIC_XY_W-1:0] ay_e, az_e, x0, y0, xs, ys;
    logic signed [CORDIC_Z_W-1:0]  z0, step_ang;
    logic [CORDIC_Z_W-1:0]         z_abs;
    logic [QW-1:0]                 q_raw, q_lim;
    logic signed [PITCH_W-1:0]     pitch_rnd;

    always_comb begin
        ay_e = CORDIC_XY_W'(i_ay);
        az_e = CORDIC_XY_W'(i_az);
        // rotate into the right half-plane
        if (az_e < 0) begin
            if (ay_e >= 0) begin
                x0 = ay_e;
                y0 = -az_e;
                z0 = QUARTER_TURN;
            end else begin
                x0 = -ay_e;
                y0 = az_e;
                z0 = -QUARTER_TURN;
            end
        end else begin
            x0 = az_e;
            y0 = ay_e;
            z0 = '0;
        end
        xs       = r_x >>> r_i;
        ys       = r_y >>> r_i;
        step_ang = atan_entry(5'(r_i));
        // round half away from zero, then clamp
        z_abs    = r_z[CORDIC_Z_W-1] ? CORDIC_Z_W'(-r_z) : CORDIC_Z_W'(r_z);
        q_raw    = QW'((z_abs + CORDIC_Z_W'(512)) >> 10);
        q_lim    = (q_raw > QW'(PITCH_LIMIT)) ? QW'(PITCH_LIMIT) : q_raw;
        pitch_rnd = r_z[CORDIC_Z_W-1] ? -PITCH_W'($signed({1'b0, q_lim}))
                                      : PITCH_W'($signed({1'b0, q_lim}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs   <= CS_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_cs)
                CS_IDLE: begin
                    if (i_start) begin
                        r_zero <= (i_ay == 16'sd0) && (i_az == 16'sd0);
                        r_x    <= x0 <<< 8;
                        r_y    <= y0 <<< 8;
                        r_z    <= z0;
                        r_i    <= '0;
                        r_cs   <= CS_ITER;
                    end
                end
                CS_ITER: begin
                    if (!r_y[CORDIC_XY_W-1]) begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + step_ang;
                    end else begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - step_ang;
                    end
                    r_i <= r_i + IW'(1);
                    if (r_i == IW'(CORDIC_STEPS - 1)) begin
                        r_cs <= CS_ROUND;
                    end
                end
                CS_ROUND: begin
                    r_pitch <= r_zero ? '0 : pitch_rnd;
                    r_done  <= 1'b1;
                    r_cs    <= CS_IDLE;
                end
                default: r_cs <= CS_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_pitch = r_pitch;

endmodule

// ----- dv/tb.sv -----
// Testbench of the IMU shake and tilt gesture detector: stimulus, predictor and checker.
`timescale 1ns / 100ps

module tb;
    import isgd_pkg::*;

    // Clock, reset and block ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_in_word    i_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_out_word   o_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    always #2 i_clk = ~i_clk;

    imu_shake_tilt_gesture_detector dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Predictor copy of the configuration
    logic [14:0] gyro_thr;
    logic [15:0] shake_trig, shake_cool, tilt_cool, calib_delay;
    logic [13:0] tilt_thr;

    // Predictor copy of the detector state
    logic [23:0] shake_acc;
    logic [31:0] last_gyro, last_shake, calib_start, last_tilt;
    logic signed [15:0] neutral;
    logic        calibrated;

    t_in_word  sample_q[$];
    t_out_word gesture_q[$];
    int        errors = 0;
    int        words_in = 0;
    int        words_out = 0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    bit        stim_done = 0;
    int        cfg_writes = 0;

    // Pitch in 1/64 degree by the same CORDIC the block uses; angles in 1/65536 degree.
    function automatic logic signed [15:0] pitch_of(input logic signed [15:0] ay,
                                                   input logic signed [15:0] az);
        longint x, y, z, t, xs, ys, r;
        longint atan_deg[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
            58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
        if (ay == 0 && az == 0) return 0;
        x = az; y = ay; z = 0;
        // rotate into the right half-plane first
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 90 * 65536;
            end else begin
                t = x; x = -y; y = t; z = -90 * 65536;
            end
        end
        x = x * 256; y = y * 256;
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i; ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += atan_deg[i];
            end else begin
                x -= ys; y += xs; z -= atan_deg[i];
            end
        end
        // round halves away from zero, then clamp to a half turn
        r = (z >= 0) ? ((z + 512) >>> 10) : -(((-z) + 512) >>> 10);
        if (r > 11520) r = 11520;
        if (r < -11520) r = -11520;
        return r[15:0];
    endfunction

    function automatic t_out_word predict_gesture(input t_in_word s);
        t_out_word res;
        longint gx, gy, gz, mag2, thr2, acc;
        logic [31:0] dt;
        logic signed [15:0] pitch;
        int delta, mag;
        res = '0;
        if (s.gyro_ok) begin
            gx = s.gyro_x; gy = s.gyro_y; gz = s.gyro_z;
            mag2 = gx * gx + gy * gy + gz * gz;
            thr2 = longint'(gyro_thr) * gyro_thr;
            dt = s.now_ms - last_gyro;
            if (dt > 100) dt = 100;
            last_gyro = s.now_ms;
            acc = shake_acc;
            if (mag2 > thr2) begin
                acc += 10 * dt;
                if (acc > 24'hFFFFFF) acc = 24'hFFFFFF;
            end else begin
                acc = (acc > 3 * dt) ? acc - 3 * dt : 0;
            end
            shake_acc = acc[23:0];
            if (acc >= 10 * longint'(shake_trig) && (s.now_ms - last_shake) >= shake_cool) begin
                shake_acc = '0;
                last_shake = s.now_ms;
                res.shake_fire = 1'b1;
            end
        end
        pitch = s.accel_ok ? pitch_of(s.accel_y, s.accel_z) : 16'sd0;
        if (!calibrated) begin
            if (calib_start == 0) calib_start = s.now_ms;
            else if ((s.now_ms - calib_start) > calib_delay) begin
                neutral = pitch;
                calibrated = 1'b1;
            end
        end else begin
            delta = int'(pitch) - int'(neutral);
            mag = delta < 0 ? -delta : delta;
            if (mag > tilt_thr && (s.now_ms - last_tilt) >= tilt_cool) begin
                last_tilt = s.now_ms;
                res.tilt_fire = 1'b1;
                res.tilt_positive = delta > 0;
            end
        end
        res.is_calibrated = calibrated;
        return res;
    endfunction

    // Driver: advance to the next sample once the current word is taken.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || !o_stall) begin
                if (i_valid) words_in <= words_in + 1;
                if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_data  <= sample_q.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall; check each accepted result word.
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                words_out <= words_out + 1;
                if (gesture_q.size() == 0) begin
                    $display("%0t: unexpected result word %b", $time, o_data);
                    errors++;
                end else begin
                    want = gesture_q.pop_front();
                    if (want !== o_data) begin
                        $display({"%0t: mismatch expected shake=%b tilt=%b pos=%b cal=%b,",
                            " actual shake=%b tilt=%b pos=%b cal=%b"},
                            $time, want.shake_fire, want.tilt_fire, want.tilt_positive,
                            want.is_calibrated, o_data.shake_fire, o_data.tilt_fire,
                            o_data.tilt_positive, o_data.is_calibrated);
                        errors++;
                    end
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Queue one sample and predict its result immediately (order matches acceptance).
    task automatic send_sample(input t_in_word s);
        sample_q.push_back(s);
        gesture_q.push_back(predict_gesture(s));
    endtask

    // Hold until every queued sample has been taken and every result has come.
    task automatic drain();
        while (sample_q.size() > 0 || i_valid || gesture_q.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            CFG_GYRO_THR:    gyro_thr    = val[14:0];
            CFG_SHAKE_TRIG:  shake_trig  = val;
            CFG_SHAKE_COOL:  shake_cool  = val;
            CFG_TILT_THR:    tilt_thr    = val[13:0];
            CFG_TILT_COOL:   tilt_cool   = val;
            default:         calib_delay = val;
        endcase
    endtask

    function automatic t_in_word rand_sample(input logic [31:0] t);
        t_in_word s;
        s.now_ms   = t;
        s.gyro_ok  = ($urandom_range(9) != 0);
        s.gyro_x   = 16'($urandom);
        s.gyro_y   = 16'($urandom);
        s.gyro_z   = 16'($urandom);
        // half the time gentle rates so both accumulator directions are exercised
        if ($urandom_range(1)) begin
            s.gyro_x = $signed(16'($urandom_range(4000))) - 16'sd2000;
            s.gyro_y = $signed(16'($urandom_range(4000))) - 16'sd2000;
            s.gyro_z = $signed(16'($urandom_range(4000))) - 16'sd2000;
        end
        s.accel_ok = ($urandom_range(9) != 0);
        s.accel_y  = 16'($urandom);
        s.accel_z  = 16'($urandom);
        if ($urandom_range(4) == 0) s.accel_y = '0;
        if ($urandom_range(4) == 0) s.accel_z = '0;
        return s;
    endfunction

    // Send a run of samples with random time steps, from small to huge gaps.
    task automatic random_run(input int n, inout logic [31:0] t);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0:       t += $urandom;
                1:       t += $urandom_range(2000);
                default: t += $urandom_range(30);
            endcase
            send_sample(rand_sample(t));
        end
    endtask

    initial begin
        t_in_word s;
        logic [31:0] t;
        gyro_thr = GYRO_THR_RST;  shake_trig = SHAKE_TRIG_RST; shake_cool = SHAKE_COOL_RST;
        tilt_thr = TILT_THR_RST;  tilt_cool = TILT_COOL_RST;   calib_delay = CALIB_DELAY_RST;
        shake_acc = '0; last_gyro = '0; last_shake = '0; calib_start = '0;
        last_tilt = '0; neutral = '0; calibrated = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: time zero leaves calibration unstarted, then field extremes.
        s = '0;
        send_sample(s);                                  // sample at time 0
        s = '{32'd10, 1'b1, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1, 16'sd0, 16'sd0};
        send_sample(s);                                  // zero accel vector
        s = '{32'd60, 1'b1, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 16'sd0, -16'sd100};
        send_sample(s);                                  // negative z on the axis
        s = '{32'd200, 1'b0, 16'shFFFF, 16'shFFFF, 16'shFFFF, 1'b0, 16'sh7FFF, 16'sh8000};
        send_sample(s);                                  // both reads failed
        s = '{32'd400, 1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sh8000, 16'sh8000};
        send_sample(s);                                  // quiet gyro, decay
        t = 32'd2000;
        for (int k = 0; k < 8; k++) begin               // calibrate, then shake
            t += 50;
            s = '{t, 1'b1, 16'sd30000, 16'sd0, 16'sd0, 1'b1, 16'sd100, 16'sd1000};
            send_sample(s);
        end
        s = '{t + 500, 1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd1000, 16'sd10};
        send_sample(s);                                  // positive tilt
        s = '{t + 1000, 1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b1, -16'sd1000, 16'sd10};
        send_sample(s);                                  // negative tilt
        s = '{32'hFFFF_FFF0, 1'b1, 16'sd30000, 16'sd0, 16'sd0, 1'b1, 16'sh7FFF, 16'sh7FFF};
        send_sample(s);                                  // timestamp wrap
        s = '{32'h0000_0020, 1'b1, 16'sd30000, 16'sd0, 16'sd0, 1'b1, -16'sd5, -16'sd7};
        send_sample(s);
        t = 32'h20;
        drain();

        // Random phases, each under a set of settings and one of four idle and stall patterns.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 64; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 64; end
                default: begin send_idle_pct = 29; stall_pct = 29; end
            endcase
            case (ph)
                0: begin
                    write_reg(CFG_GYRO_THR, 16'd0);      write_reg(CFG_SHAKE_TRIG, 16'd0);
                    write_reg(CFG_SHAKE_COOL, 16'd0);    write_reg(CFG_TILT_THR, 16'd0);
                    write_reg(CFG_TILT_COOL, 16'd0);     write_reg(CFG_CALIB_DELAY, 16'd0);
                end
                1: begin
                    write_reg(CFG_GYRO_THR, 16'h7FFF);   write_reg(CFG_SHAKE_TRIG, 16'hFFFF);
                    write_reg(CFG_SHAKE_COOL, 16'hFFFF); write_reg(CFG_TILT_THR, 16'h3FFF);
                    write_reg(CFG_TILT_COOL, 16'hFFFF);  write_reg(CFG_CALIB_DELAY, 16'hFFFF);
                end
                2: begin
                    write_reg(CFG_GYRO_THR, 16'd11520);  write_reg(CFG_TILT_THR, 16'd11520);
                    write_reg(CFG_SHAKE_TRIG, 16'd20);   write_reg(CFG_SHAKE_COOL, 16'd50);
                    write_reg(CFG_TILT_COOL, 16'd20);    write_reg(CFG_CALIB_DELAY, 16'd10);
                end
                default: begin
                    write_reg(CFG_GYRO_THR, 16'($urandom_range(3000)));
                    write_reg(CFG_SHAKE_TRIG, 16'($urandom_range(200)));
                    write_reg(CFG_SHAKE_COOL, 16'($urandom_range(500)));
                    write_reg(CFG_TILT_THR, 16'($urandom_range(4000)));
                    write_reg(CFG_TILT_COOL, 16'($urandom_range(300)));
                    write_reg(CFG_CALIB_DELAY, 16'($urandom_range(100)));
                end
            endcase
            random_run(215, t);
            drain();   // sender holds off until every result is in
        end
        stim_done = 1;
    end

    // End of run: summary and verdict.
    initial begin
        wait (stim_done);
        repeat (200) @(posedge i_clk);
        if (gesture_q.size() != 0) begin
            $display("%0t: %0d expected result words never arrived", $time, gesture_q.size());
            errors++;
        end
        $display("Ran %0d samples and %0d result words over 8 setting phases, %0d register writes.",
            words_in, words_out, cfg_writes);
        if (errors == 0)
            $display("** imu_shake_tilt_gesture_detector: PASSED **");
        else
            $display("** imu_shake_tilt_gesture_detector: FAILED **");
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("** imu_shake_tilt_gesture_detector: FAILED **");
        $finish;
    end

endmodule
